>>> sv/rsd_pkg.sv
// rsd_pkg: shared types and defaults for the restoring signed divider
// no dependencies; used by every rsd_* module and the top level
`timescale 1ns / 1ps
`default_nettype none

package rsd_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    // side information that travels with each item down the pipeline
    typedef struct packed {
        logic valid;
        logic negate;
        logic overflow;
        logic div_zero;
    } t_flags;

endpackage

`default_nettype wire

>>> sv/rsd_prep.sv
// rsd_prep: input stage, operand magnitudes, sign and special case flags
// depends on rsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rsd_prep #(
    parameter int DATA_WIDTH = rsd_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic [DATA_WIDTH-1:0] i_dividend,
    input  wire logic [DATA_WIDTH-1:0] i_divisor,
    output rsd_pkg::t_flags            o_flags,
    output logic      [DATA_WIDTH-1:0] o_num,
    output logic      [DATA_WIDTH-1:0] o_den
);

    localparam logic [DATA_WIDTH-1:0] MinVal = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    rsd_pkg::t_flags       r_flags;
    rsd_pkg::t_flags       n_flags;
    logic [DATA_WIDTH-1:0] r_num;
    logic [DATA_WIDTH-1:0] r_den;
    logic                  a_neg;
    logic                  b_neg;
    logic                  a_pos;
    logic                  b_pos;

    always_comb begin
        a_neg            = i_dividend[DATA_WIDTH-1];
        b_neg            = i_divisor[DATA_WIDTH-1];
        a_pos            = !a_neg && (|i_dividend);
        b_pos            = !b_neg && (|i_divisor);
        n_flags.valid    = i_accept;
        n_flags.negate   = (a_pos && b_neg) || (a_neg && b_pos);
        n_flags.overflow = (i_dividend == MinVal) && (&i_divisor);
        n_flags.div_zero = !(|i_divisor);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_num <= a_neg ? (~i_dividend + 1'b1) : i_dividend;
        r_den <= b_neg ? (~i_divisor + 1'b1) : i_divisor;
    end

    assign o_flags = r_flags;
    assign o_num   = r_num;
    assign o_den   = r_den;

endmodule

`default_nettype wire

>>> sv/rsd_step.sv
// rsd_step: one restoring division step, one quotient bit per stage
// depends on rsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rsd_step #(
    parameter int DATA_WIDTH = rsd_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire rsd_pkg::t_flags       i_flags,
    input  wire logic [DATA_WIDTH-1:0] i_rem,
    input  wire logic [DATA_WIDTH-1:0] i_nq,
    input  wire logic [DATA_WIDTH-1:0] i_den,
    output rsd_pkg::t_flags            o_flags,
    output logic      [DATA_WIDTH-1:0] o_rem,
    output logic      [DATA_WIDTH-1:0] o_nq,
    output logic      [DATA_WIDTH-1:0] o_den
);

    rsd_pkg::t_flags       r_flags;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_nq;
    logic [DATA_WIDTH-1:0] r_den;
    logic [DATA_WIDTH-1:0] n_rem;
    logic [DATA_WIDTH-1:0] n_nq;
    logic [DATA_WIDTH-1:0] rem_sh;
    logic [DATA_WIDTH+1:0] trial;
    logic                  take;

    // nq holds the dividend bits still to come, quotient bits enter from the bottom
    always_comb begin
        rem_sh = {i_rem[DATA_WIDTH-2:0], i_nq[DATA_WIDTH-1]};
        trial  = {1'b0, i_rem[DATA_WIDTH-1], rem_sh} - {2'b00, i_den};
        take   = !trial[DATA_WIDTH+1];
        n_rem  = take ? trial[DATA_WIDTH-1:0] : rem_sh;
        n_nq   = {i_nq[DATA_WIDTH-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_nq  <= n_nq;
        r_den <= i_den;
    end

    assign o_flags = r_flags;
    assign o_rem   = r_rem;
    assign o_nq    = r_nq;
    assign o_den   = r_den;

endmodule

`default_nettype wire

>>> sv/rsd_post.sv
// rsd_post: output stage, applies the quotient sign and drives the result strobe
// depends on rsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rsd_post #(
    parameter int DATA_WIDTH = rsd_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire rsd_pkg::t_flags       i_flags,
    input  wire logic [DATA_WIDTH-1:0] i_quo,
    output logic                       o_valid,
    output logic      [DATA_WIDTH-1:0] o_quotient,
    output logic                       o_overflow,
    output logic                       o_divide_by_zero
);

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_quotient;
    logic [DATA_WIDTH-1:0] n_quotient;
    logic                  r_overflow;
    logic                  r_div_zero;

    assign n_quotient = i_flags.negate ? (~i_quo + 1'b1) : i_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_flags.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quotient <= n_quotient;
        r_overflow <= i_flags.overflow;
        r_div_zero <= i_flags.div_zero;
    end

    assign o_valid          = r_valid;
    assign o_quotient       = r_quotient;
    assign o_overflow       = r_overflow;
    assign o_divide_by_zero = r_div_zero;

endmodule

`default_nettype wire

>>> sv/restoring_signed_divider.sv
// restoring_signed_divider: top level of the pipelined signed restoring divider
// depends on rsd_pkg, rsd_prep, rsd_step, rsd_post
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | start, busy        | i_dividend, i_divisor
//  result   | o_valid (strobe)   | o_quotient, o_overflow, o_divide_by_zero
//
// one item is accepted per cycle while busy is low; each item passes through every stage
// of the pipeline: the step chain, one quotient bit per stage, one subtract each,
// plus one stage for operand magnitudes and one for the sign of the quotient
// synchronous reset flushes all valid bits; busy is high in reset and in the cycle after it is released
// the result strobe is a single cycle and cannot be held off
`timescale 1ns / 1ps
`default_nettype none

module restoring_signed_divider #(
    parameter int DATA_WIDTH = rsd_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [DATA_WIDTH-1:0] i_dividend,
    input  wire logic [DATA_WIDTH-1:0] i_divisor,
    output logic                       o_valid,
    output logic      [DATA_WIDTH-1:0] o_quotient,
    output logic                       o_overflow,
    output logic                       o_divide_by_zero
);

    localparam int Latency = DATA_WIDTH + 2;

    logic                  r_busy;
    logic                  accept;
    rsd_pkg::t_flags       s_flags [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] s_rem   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] s_nq    [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] s_den   [0:DATA_WIDTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign accept   = start && !r_busy;
    assign s_rem[0] = '0;

    rsd_prep #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_flags    (s_flags[0]),
        .o_num      (s_nq[0]),
        .o_den      (s_den[0])
    );

    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
        rsd_step #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_flags (s_flags[k]),
            .i_rem   (s_rem[k]),
            .i_nq    (s_nq[k]),
            .i_den   (s_den[k]),
            .o_flags (s_flags[k+1]),
            .o_rem   (s_rem[k+1]),
            .o_nq    (s_nq[k+1]),
            .o_den   (s_den[k+1])
        );
    end

    rsd_post #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_post (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_flags          (s_flags[DATA_WIDTH]),
        .i_quo            (s_nq[DATA_WIDTH]),
        .o_valid          (o_valid),
        .o_quotient       (o_quotient),
        .o_overflow       (o_overflow),
        .o_divide_by_zero (o_divide_by_zero)
    );

`ifndef ASSERT_OFF
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_overflow && o_divide_by_zero))
        else $error("overflow and divide by zero flagged together");

    a_div_zero_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |-> (&o_quotient))
        else $error("zero divisor did not give all ones quotient");

    a_overflow_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |->
        (o_quotient == {1'b1, {(DATA_WIDTH-1){1'b0}}}))
        else $error("overflow result is not the most negative value");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, Latency))
        else $error("result strobe without an item accepted at the pipeline latency");
`endif

endmodule

`default_nettype wire
